### sv/tgarle_pkg.sv
// Shared types and constants for the TGA run-length pixel decoder.
`timescale 1ns / 1ps

package tgarle_pkg;

	// Width of the pixel position and pixel count.
	localparam int POS_W = 32;

	// Largest pixel count that the position can reach without wrapping.
	localparam logic [32:0] POS_LIMIT = (33'd1 << POS_W) - 33'd1;

	// Pixel size code that selects four-byte BGRA pixels.
	localparam logic [2:0] BPP_WIDE = 3'd4;
	localparam logic [2:0] BPP_NARROW = 3'd3;

	typedef enum logic [1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_BPP    = 2'd2,
		CFG_RLE    = 2'd3
	} cfg_idx_t;

	// Result of clipping one fill command against the image end.
	typedef struct packed {
		logic [7:0] len;
		logic       last;
		logic       clip;
	} fill_t;

endpackage

### sv/tgarle_fill.sv
// Clips a fill command against the pixels left in the image.
`timescale 1ns / 1ps

module tgarle_fill
	import tgarle_pkg::*;
(
	input  logic [POS_W-1:0] pos,
	input  logic [POS_W-1:0] count,
	input  logic [7:0]       want,
	output fill_t            fill
);

	logic [POS_W:0] diff;
	logic           nonpos;
	logic           near_end;
	logic [7:0]     d8;

	// One subtract gives the pixels left; all other checks are narrow.
	assign diff     = {1'b0, count} - {1'b0, pos};
	assign nonpos   = diff[POS_W] || (diff == '0);
	assign near_end = (diff[POS_W:8] == '0);
	assign d8       = diff[7:0];

	always_comb begin
		if (nonpos) begin
			// Count already reached: write a single pixel and close the image.
			fill.len  = 8'd1;
			fill.last = 1'b1;
			fill.clip = (want > 8'd1);
		end else if (near_end && (want >= d8)) begin
			fill.len  = d8;
			fill.last = 1'b1;
			fill.clip = (want > d8);
		end else begin
			fill.len  = want;
			fill.last = 1'b0;
			fill.clip = 1'b0;
		end
	end

endmodule

### sv/tga_rle_pixel_decoder_core.sv
// A byte goes into the input stage register; a pixel's last byte then loads the output register.
// Throughput: one byte per cycle unless the output stalls; the output register holds a finished word.
// The pixel count register is loaded from the width and height registers.
// Reset clears the decoder state and loads width 1, height 1, 3-byte pixels, RLE on.
// Top level of the TGA run-length pixel decoder.
`timescale 1ns / 1ps

module tga_rle_pixel_decoder_core
	import tgarle_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] start_pixel,
	output logic [7:0]  run_length,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic        last_of_image,
	output logic        overflow,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// Configuration.
	logic [15:0]      width_q;
	logic [15:0]      height_q;
	logic [2:0]       bpp_q;
	logic             rle_q;
	logic [POS_W-1:0] count_q;
	logic [31:0]      prod;

	// Decoder state.
	logic             expect_q;
	logic             run_q;
	logic [7:0]       left_q;
	logic [1:0]       bip_q;
	logic [31:0]      color_q;
	logic [POS_W-1:0] pos_q;

	// Input stage.
	logic             valid_s1;
	logic [7:0]       byte_s1;

	// Output register.
	logic             out_valid_q;
	logic [31:0]      start_q;
	logic [7:0]       len_q;
	logic [7:0]       red_q;
	logic [7:0]       green_q;
	logic [7:0]       blue_q;
	logic [7:0]       alpha_q;
	logic             last_q;
	logic             over_q;

	logic             go;
	logic             bpp4;
	logic             hdr;
	logic             pix_done;
	logic             emit;
	logic [31:0]      color_nx;
	logic [7:0]       left_eff;
	logic [7:0]       left_raw;
	logic [7:0]       want;
	logic             raw_pkt;
	logic             more_raw;
	fill_t            fill;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 16'd1;
			height_q <= 16'd1;
			bpp_q    <= BPP_NARROW;
			rle_q    <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				CFG_BPP:    bpp_q    <= cfg_data[2:0];
				CFG_RLE:    rle_q    <= cfg_data[0];
			endcase
		end
	end

	// The pixel count is registered so the multiplier stays off the byte path.
	assign prod = width_q * height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= POS_W'(1);
		end else if ({1'b0, prod} > POS_LIMIT) begin
			count_q <= POS_LIMIT[POS_W-1:0];
		end else begin
			count_q <= prod[POS_W-1:0];
		end
	end

	assign go       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
		end
	end

	assign bpp4 = (bpp_q == BPP_WIDE);
	assign hdr  = rle_q && expect_q;

	always_comb begin
		color_nx = color_q;
		color_nx[bip_q*8 +: 8] = byte_s1;
	end

	assign pix_done = (({1'b0, bip_q} + 3'd1) >= (bpp4 ? BPP_WIDE : BPP_NARROW));
	assign emit     = !hdr && pix_done;
	assign left_eff = (left_q == 8'd0) ? 8'd1 : left_q;
	assign left_raw = left_eff - 8'd1;
	assign raw_pkt  = rle_q && !run_q;
	assign more_raw = raw_pkt && (left_raw != 8'd0);
	assign want     = (rle_q && run_q) ? left_eff : 8'd1;

	tgarle_fill u_fill (
		.pos   (pos_q),
		.count (count_q),
		.want  (want),
		.fill  (fill)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_q <= 1'b1;
			run_q    <= 1'b0;
			left_q   <= 8'd0;
			bip_q    <= 2'd0;
			color_q  <= 32'd0;
			pos_q    <= '0;
		end else if (go) begin
			if (hdr) begin
				// Both packet kinds carry their pixel count minus one in the low bits.
				run_q    <= byte_s1[7];
				left_q   <= {1'b0, byte_s1[6:0]} + 8'd1;
				expect_q <= 1'b0;
				bip_q    <= 2'd0;
			end else begin
				color_q <= color_nx;
				if (!pix_done) begin
					bip_q <= bip_q + 2'd1;
				end else begin
					bip_q <= 2'd0;
					if (fill.last) begin
						pos_q    <= '0;
						expect_q <= 1'b1;
						run_q    <= 1'b0;
						left_q   <= 8'd0;
					end else begin
						pos_q <= pos_q + POS_W'(fill.len);
						if (raw_pkt) begin
							left_q   <= left_raw;
							expect_q <= (left_raw == 8'd0);
						end else begin
							left_q   <= 8'd0;
							expect_q <= 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			start_q <= 32'(pos_q);
			len_q   <= fill.len;
			red_q   <= color_nx[23:16];
			green_q <= color_nx[15:8];
			blue_q  <= color_nx[7:0];
			alpha_q <= bpp4 ? color_nx[31:24] : 8'd0;
			last_q  <= fill.last;
			// A raw packet cut short by the image end is reported as well.
			over_q  <= fill.clip || (fill.last && more_raw);
		end
	end

	assign out_valid     = out_valid_q;
	assign start_pixel   = start_q;
	assign run_length    = len_q;
	assign red           = red_q;
	assign green         = green_q;
	assign blue          = blue_q;
	assign alpha         = alpha_q;
	assign last_of_image = last_q;
	assign overflow      = over_q;

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (len_q != 8'd0))
		else $error("fill word with zero run length");

	a_over_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && over_q) |-> last_q)
		else $error("overflow flagged on a word that does not close the image");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(go && emit && fill.last) |=> ((pos_q == '0) && expect_q))
		else $error("decoder did not restart after the last word of an image");

	a_no_emit_on_header: assert property (@(posedge clk) disable iff (!arst_n)
		(go && hdr) |=> (out_valid_q == $past(out_valid_q && !out_ready)))
		else $error("packet header produced a fill word");

endmodule

### sim/tga_fill_checker.sv
// Watches the decoder's channels, predicts each fill command and compares it with the block.
`timescale 1ns / 1ps

module tga_fill_checker
	import tgarle_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] start_pixel,
	input  logic [7:0]  run_length,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [7:0]  alpha,
	input  logic        last_of_image,
	input  logic        overflow,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatches,
	output int          fills_waiting
);

	typedef struct packed {
		logic [31:0] start;
		logic [7:0]  len;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [7:0]  a;
		logic        last;
		logic        over;
	} fill_cmd_t;

	fill_cmd_t fills_due[$];

	// Register copies.
	logic [15:0] img_w;
	logic [15:0] img_h;
	logic [2:0]  pix_size;
	logic        rle_on;

	// Decoder state copies.
	logic        want_header;
	logic        in_run;
	logic [7:0]  pkt_left;
	logic [1:0]  byte_idx;
	logic [31:0] color;
	logic [31:0] pix_pos;

	assign fills_waiting = fills_due.size();

	function automatic void restart_image();
		pix_pos = '0;
		want_header = 1'b1;
		in_run = 1'b0;
		pkt_left = '0;
		byte_idx = '0;
	endfunction

	// Feeds one byte through the decoder copy; returns 1 when it completes a fill command.
	function automatic logic decode_byte(input logic [7:0] b, output fill_cmd_t cmd);
		int          nbytes;
		logic [63:0] product;
		logic [32:0] count;
		logic [32:0] pos;
		logic [32:0] remaining;
		logic [32:0] want;
		logic [32:0] len;
		logic        over;
		logic        last;
		logic        more_raw;
		nbytes = (pix_size == BPP_WIDE) ? 4 : 3;
		over = 1'b0;
		last = 1'b0;
		more_raw = 1'b0;
		cmd = '0;

		if (rle_on && want_header) begin
			if (b < 8'd128) begin
				in_run = 1'b0;
				pkt_left = b + 8'd1;
			end else begin
				in_run = 1'b1;
				pkt_left = b - 8'd127;
			end
			want_header = 1'b0;
			byte_idx = '0;
			return 1'b0;
		end

		color[8*byte_idx +: 8] = b;
		if (int'(byte_idx) + 1 < nbytes) begin
			byte_idx = byte_idx + 2'd1;
			return 1'b0;
		end
		byte_idx = '0;

		if (pkt_left == 8'd0)
			pkt_left = 8'd1;

		if (!rle_on) begin
			want = 33'd1;
			want_header = 1'b1;
			pkt_left = '0;
		end else if (in_run) begin
			want = 33'(pkt_left);
			want_header = 1'b1;
			pkt_left = '0;
		end else begin
			want = 33'd1;
			pkt_left = pkt_left - 8'd1;
			if (pkt_left == 8'd0)
				want_header = 1'b1;
			else
				more_raw = 1'b1;
		end

		product = 64'(img_w) * 64'(img_h);
		count = (product < 64'(POS_LIMIT)) ? product[32:0] : POS_LIMIT;
		pos = 33'(pix_pos);
		remaining = (pos < count) ? count - pos : 33'd1;
		len = want;
		if (len > remaining) begin
			len = remaining;
			over = 1'b1;
		end
		if (pos + len >= count) begin
			last = 1'b1;
			if (more_raw)
				over = 1'b1;
		end

		cmd.start = pos[31:0];
		cmd.len = len[7:0];
		cmd.r = color[23:16];
		cmd.g = color[15:8];
		cmd.b = color[7:0];
		cmd.a = (nbytes == 4) ? color[31:24] : 8'd0;
		cmd.last = last;
		cmd.over = over;

		if (last)
			restart_image();
		else
			pix_pos = pos[31:0] + len[31:0];
		return 1'b1;
	endfunction

	task automatic report(input string what, input fill_cmd_t exp_cmd, input fill_cmd_t got);
		if (mismatches < 10) begin
			$display("%0t: %s", $realtime, what);
			$display("  expected start=%0d len=%0d rgba=%h %h %h %h last=%b over=%b",
				exp_cmd.start, exp_cmd.len, exp_cmd.r, exp_cmd.g, exp_cmd.b, exp_cmd.a,
				exp_cmd.last, exp_cmd.over);
			$display("  actual   start=%0d len=%0d rgba=%h %h %h %h last=%b over=%b",
				got.start, got.len, got.r, got.g, got.b, got.a, got.last, got.over);
		end
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		fill_cmd_t got;
		fill_cmd_t exp_cmd;
		fill_cmd_t next_cmd;
		if (!arst_n) begin
			img_w = 16'd1;
			img_h = 16'd1;
			pix_size = BPP_NARROW;
			rle_on = 1'b1;
			color = '0;
			restart_image();
			fills_due.delete();
			mismatches = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{start_pixel, run_length, red, green, blue, alpha,
					last_of_image, overflow};
				if (fills_due.size() == 0) begin
					report("fill command with none expected", '0, got);
				end else begin
					exp_cmd = fills_due.pop_front();
					if (got.start !== exp_cmd.start || got.len !== exp_cmd.len ||
						got.r !== exp_cmd.r || got.g !== exp_cmd.g ||
						got.b !== exp_cmd.b || got.a !== exp_cmd.a ||
						got.last !== exp_cmd.last || got.over !== exp_cmd.over)
						report("fill command mismatch", exp_cmd, got);
				end
			end

			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_WIDTH:  img_w = cfg_data;
					CFG_HEIGHT: img_h = cfg_data;
					CFG_BPP:    pix_size = cfg_data[2:0];
					CFG_RLE:    rle_on = cfg_data[0];
					default:    ;
				endcase
			end

			if (in_valid && in_ready) begin
				if (decode_byte(data_byte, next_cmd))
					fills_due.push_back(next_cmd);
			end
		end
	end

endmodule

### sim/tb.sv
// Testbench top: drives byte streams and register settings into the TGA RLE decoder.
`timescale 1ns / 1ps

module tb
	import tgarle_pkg::*;
();

	localparam int CYCLE_LIMIT = 2000000;
	localparam int RANDOM_BYTES = 2000;
	localparam int HOLD_CYCLES = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] start_pixel;
	logic [7:0]  run_length;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic        last_of_image;
	logic        overflow;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	int mismatches;
	int fills_waiting;
	int cycle_count = 0;
	int bytes_sent = 0;
	logic idle_on = 1'b1;
	logic hold_go = 1'b0;
	logic rx_hold = 1'b0;
	logic [2:0] cur_bpp = BPP_NARROW;
	logic cur_rle = 1'b1;

	always #5 clk = ~clk;

	tga_rle_pixel_decoder_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.start_pixel(start_pixel), .run_length(run_length),
		.red(red), .green(green), .blue(blue), .alpha(alpha),
		.last_of_image(last_of_image), .overflow(overflow),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	tga_fill_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.start_pixel(start_pixel), .run_length(run_length),
		.red(red), .green(green), .blue(blue), .alpha(alpha),
		.last_of_image(last_of_image), .overflow(overflow),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .fills_waiting(fills_waiting)
	);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Receiver: random stalls, plus the long hold-off when it is on.
	initial begin : receiver
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (rx_hold || stall > 0) begin
				out_ready <= 1'b0;
				if (stall > 0)
					stall--;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall = pick_gap();
			end
		end
	end

	// One long hold-off on the result side so the block backs up into its input.
	initial begin : hold_off
		wait (hold_go);
		@(negedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		rx_hold <= 1'b0;
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	// Drains every outstanding command, then lets the pipeline settle.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (fills_waiting != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_BPP)
			cur_bpp = value[2:0];
		if (idx == CFG_RLE)
			cur_rle = value[0];
	endtask

	task automatic set_image(input logic [15:0] w, input logic [15:0] h,
		input logic [15:0] bpp, input logic [15:0] rle);
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
		write_reg(CFG_BPP, bpp);
		write_reg(CFG_RLE, rle);
		// The pixel count register lags the register writes.
		repeat (2) @(negedge clk);
	endtask

	task automatic send_pixel(input int nbytes);
		repeat (nbytes) send_byte(8'($urandom_range(0, 255)));
	endtask

	function automatic logic [15:0] pick_dim();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'd1;
			2, 3, 4, 5: return 16'($urandom_range(1, 6));
			6, 7: return 16'($urandom_range(7, 40));
			8: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [7:0] pick_header();
		int r;
		r = $urandom_range(0, 19);
		if (r < 8)
			return 8'($urandom_range(0, 3));
		if (r == 8)
			return 8'($urandom_range(0, 127));
		if (r < 18)
			return 8'($urandom_range(128, 255));
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return 8'd127;
			2: return 8'd128;
			default: return 8'd255;
		endcase
	endfunction

	// A run-length packet with random content; now and then cut short or preceded by noise.
	task automatic send_packet(input int nbytes);
		logic [7:0] hdr;
		int pixels;
		int total;
		if ($urandom_range(0, 19) == 0)
			send_byte(8'($urandom_range(0, 255)));
		hdr = pick_header();
		pixels = (hdr < 8'd128) ? int'(hdr) + 1 : 1;
		total = pixels * nbytes;
		if ($urandom_range(0, 19) == 0)
			total = $urandom_range(0, total);
		send_byte(hdr);
		send_pixel(total);
	endtask

	initial begin : stimulus
		int nbytes;
		int phase_len;
		int phase_start;
		int r;
		logic [15:0] bpp_val;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Reset setting: one 3-byte pixel image in run-length mode.
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h80);
		drain();

		// A 128-copy run clipped to a two-pixel image, then a raw packet cut off.
		set_image(16'd2, 16'd1, 16'(BPP_WIDE), 16'd1);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h02);
		send_pixel(8);
		drain();

		// Uncompressed mode with a pixel size code that falls back to three bytes.
		set_image(16'd1, 16'd2, 16'd7, 16'd0);
		send_pixel(6);
		drain();

		bytes_sent = 0;
		hold_go = 1'b1;
		while (bytes_sent < RANDOM_BYTES) begin
			r = $urandom_range(0, 9);
			if (r < 4)
				bpp_val = 16'(BPP_NARROW);
			else if (r < 8)
				bpp_val = 16'(BPP_WIDE);
			else
				bpp_val = 16'($urandom_range(0, 7));
			set_image(pick_dim(), pick_dim(), bpp_val,
				16'($urandom_range(0, 4) != 0));
			idle_on = ($urandom_range(0, 3) != 0);
			nbytes = (cur_bpp == BPP_WIDE) ? 4 : 3;
			phase_len = $urandom_range(40, 200);
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < phase_len) begin
				if (cur_rle)
					send_packet(nbytes);
				else
					send_pixel(nbytes);
			end
			drain();
		end
		idle_on = 1'b1;

		if (mismatches == 0 && fills_waiting == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### files.f
sv/tgarle_pkg.sv
sv/tgarle_fill.sv
sv/tga_rle_pixel_decoder_core.sv
sim/tga_fill_checker.sv
sim/tb.sv
